// ===== sv/leb_pkg.sv =====
// Shared types and constants for the line edit buffer.
`timescale 1ns / 1ps

package leb_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ERASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_KILL  = 1'b1;

	localparam logic [CHAR_W-1:0] ERASE_RST    = 8'h23;
	localparam logic [CHAR_W-1:0] KILL_RST     = 8'h40;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

	typedef logic [CHAR_W-1:0] char_t;

	// controller to datapath
	typedef struct packed {
		logic store;
		logic erase;
		logic kill;
		logic advance;
		logic finish;
	} leb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_erase;
		logic is_kill;
		logic flush_hit;
		logic last;
	} leb_stat_t;

endpackage

// ===== sv/leb_ctrl.sv =====
// Controller state machine: takes characters, sequences a line flush.
`timescale 1ns / 1ps

module leb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  leb_pkg::leb_stat_t stat,
	output leb_pkg::leb_cmd_t  cmd
);
	import leb_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PRIME = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (stat.is_erase) begin
						cmd.erase = 1'b1;
					end else if (stat.is_kill) begin
						cmd.kill = 1'b1;
					end else begin
						cmd.store = 1'b1;
						if (stat.flush_hit) begin
							state_d = ST_PRIME;
						end
					end
				end
			end
			// wait out the registered read of the first entry
			ST_PRIME: begin
				state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (stat.last) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/leb_dp.sv =====
// Datapath: control registers, line store, fill count and read pointer.
`timescale 1ns / 1ps

module leb_dp #(
	parameter int unsigned LINE_CAPACITY = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  leb_pkg::char_t             cfg_data,
	input  leb_pkg::char_t             in_char,
	input  leb_pkg::leb_cmd_t          cmd,
	output leb_pkg::leb_stat_t         stat,
	output leb_pkg::char_t             out_char,
	output logic                       last_of_run
);
	import leb_pkg::*;

	localparam int unsigned AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
	localparam int unsigned FW = $clog2(LINE_CAPACITY + 1);

	char_t          erase_q;
	char_t          kill_q;
	logic [FW-1:0]  fill_q;
	logic [AW-1:0]  ptr_q;
	logic [AW-1:0]  rd_addr;
	char_t          rd_data_q;
	char_t          line_mem [LINE_CAPACITY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_q <= ERASE_RST;
			kill_q  <= KILL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ERASE: erase_q <= cfg_data;
				REG_KILL:  kill_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		stat.is_erase  = (in_char == erase_q);
		stat.is_kill   = (in_char == kill_q);
		stat.flush_hit = (in_char == NEWLINE_CODE) || (fill_q == FW'(LINE_CAPACITY - 1));
		stat.last      = ((FW'(ptr_q) + FW'(1)) == fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ptr_q  <= '0;
		end else begin
			if (cmd.store) begin
				fill_q <= fill_q + FW'(1);
			end else if (cmd.erase) begin
				if (fill_q != '0) begin
					fill_q <= fill_q - FW'(1);
				end
			end else if (cmd.kill || cmd.finish) begin
				fill_q <= '0;
			end
			if (cmd.finish) begin
				ptr_q <= '0;
			end else if (cmd.advance) begin
				ptr_q <= ptr_q + AW'(1);
			end
		end
	end

	// fetch the next entry as soon as the current beat is taken
	assign rd_addr = cmd.advance ? (ptr_q + AW'(1)) : ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			line_mem[fill_q[AW-1:0]] <= in_char;
		end
		rd_data_q <= line_mem[rd_addr];
	end

	assign out_char    = rd_data_q;
	assign last_of_run = stat.last;

endmodule

// ===== sv/line_edit_buffer.sv =====
// Top level of the line edit buffer.
`timescale 1ns / 1ps

// Terminal-style line editor. Characters are taken one per cycle while no line
// is being flushed: the erase character drops the last stored character (none
// at the start of a line), the kill character empties the line, and any other
// character, newline included, is stored. Erase wins when erase and kill codes
// match. A stored newline, or a store that reaches LINE_CAPACITY characters,
// flushes the line in order on the output channel with last_of_run set on its
// final beat, and the next line starts empty. A flush holds off input until
// its last beat is taken: a prime state waits out the first read of the line
// memory, then one beat per cycle, unless the output stalls, comes from its
// registered read port. Control registers reset to '#' (erase) and '@' (kill).

module line_edit_buffer #(
	parameter int unsigned LINE_CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_char,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_char,
	output logic                          last_of_run
);
	import leb_pkg::*;

	leb_cmd_t  cmd;
	leb_stat_t stat;

	leb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	leb_dp #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_char     (in_char),
		.cmd         (cmd),
		.stat        (stat),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule

// ===== tb/tb_line_edit_buffer.sv =====
// Self-checking testbench for the line edit buffer: erase, kill, newline and full-store flushes.
`timescale 1ns / 1ps

module tb_line_edit_buffer;
	import leb_pkg::*;

	localparam int LINE_CAP    = 64;
	localparam int IDLE_GAP    = 4;
	localparam int DRAIN_WAIT  = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_CHARS = 6;

	typedef struct {
		char_t ch;
		logic  last;
	} line_beat_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = REG_ERASE;
	logic [7:0]           cfg_data    = 8'h00;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	logic [7:0]           in_char     = 8'h00;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [7:0]           out_char;
	logic                 last_of_run;

	// edit state mirrored from the block
	char_t      pending_line[$];
	line_beat_t flushed_beats[$];
	char_t      erase_code = ERASE_RST;
	char_t      kill_code  = KILL_RST;

	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         items_sent    = 0;
	int         fail_count    = 0;
	int         stall_cycles  = 0;
	line_beat_t head_beat;

	line_edit_buffer #(
		.LINE_CAPACITY(LINE_CAP)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_char    (in_char),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one accepted character to the mirrored line and queue any flush.
	function automatic void edit_line(char_t c);
		int k;
		if (c == erase_code) begin
			if (pending_line.size() != 0)
				void'(pending_line.pop_back());
		end else if (c == kill_code) begin
			pending_line.delete();
		end else begin
			pending_line.push_back(c);
			if (c == NEWLINE_CODE || pending_line.size() == LINE_CAP) begin
				for (k = 0; k < pending_line.size(); k++)
					flushed_beats.push_back('{ch: pending_line[k],
						last: (k == pending_line.size() - 1)});
				pending_line.delete();
			end
		end
	endfunction

	// Random byte, biased toward the current erase and kill codes.
	function automatic char_t pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return erase_code;
		if (r < 15)
			return kill_code;
		return char_t'($urandom_range(0, 255));
	endfunction

	// Random byte that is neither a control code nor a newline.
	function automatic char_t plain_char();
		char_t c;
		do
			c = char_t'($urandom_range(0, 255));
		while (c == erase_code || c == kill_code || c == NEWLINE_CODE);
		return c;
	endfunction

	// Called just after a rising edge; returns at the edge that accepts the beat.
	task automatic send_char(input char_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		do
			@(posedge clk);
		while (!in_ready);
		edit_line(c);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(char_t'(s[i]));
	endtask

	// Hold off input until every queued beat has arrived, then idle a while.
	task automatic wait_drained(input int extra);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (flushed_beats.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input char_t value);
		wait_drained(IDLE_GAP);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == REG_ERASE)
			erase_code = value;
		else
			kill_code = value;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pace(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic test_basic_lines();
		send_text("hi\n");
		send_text("#ab#c\n");      // erase at line start is dropped
		send_text("xy@z\n");
		send_text("\n");
		send_char(8'h00);
		send_char(8'hFF);
		send_char(NEWLINE_CODE);
	endtask

	task automatic test_control_codes();
		// equal codes: erase takes priority
		write_code(REG_ERASE, 8'h00);
		write_code(REG_KILL, 8'h00);
		send_text("a");
		send_char(8'h00);
		send_text("b\n");
		// newline as erase: no flush, drops the previous character
		write_code(REG_KILL, 8'hFF);
		write_code(REG_ERASE, NEWLINE_CODE);
		send_text("qr");
		send_char(NEWLINE_CODE);
		// newline as kill: empties the pending line
		write_code(REG_ERASE, 8'h00);
		write_code(REG_KILL, NEWLINE_CODE);
		send_text("s");
		send_char(NEWLINE_CODE);
		write_code(REG_ERASE, ERASE_RST);
		write_code(REG_KILL, KILL_RST);
		send_text("ok\n");
	endtask

	task automatic test_full_store();
		int k;
		// capacity reached without a newline
		for (k = 0; k < LINE_CAP; k++)
			send_char(plain_char());
	endtask

	task automatic random_line();
		int len;
		int k;
		len = $urandom_range(0, 12);
		for (k = 0; k < len; k++)
			send_char(pick_char());
		// most lines are terminated; some run on into the next one
		if ($urandom_range(0, 5) != 0)
			send_char(NEWLINE_CODE);
		if ($urandom_range(0, 7) == 0)
			wait_drained(0);
	endtask

	task automatic test_random_traffic(input char_t erase_val, input char_t kill_val);
		int start;
		write_code(REG_ERASE, erase_val);
		write_code(REG_KILL, kill_val);
		start = items_sent;
		while (items_sent - start < PHASE_CHARS)
			random_line();
	endtask

	function automatic char_t random_code();
		char_t c;
		do
			c = char_t'($urandom_range(0, 255));
		while (c == NEWLINE_CODE);
		return c;
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Compare each output beat with the oldest queued one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (flushed_beats.size() == 0) begin
				$error("out_char: no beat expected, got %h", out_char);
				fail_count++;
			end else begin
				head_beat = flushed_beats.pop_front();
				if (out_char !== head_beat.ch) begin
					$error("out_char: expected %h, got %h", head_beat.ch, out_char);
					fail_count++;
				end
				if (last_of_run !== head_beat.last) begin
					$error("last_of_run: expected %b, got %b", head_beat.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pace(35, 81);
		test_basic_lines();
		test_control_codes();
		test_full_store();

		set_pace(81, 35);
		test_random_traffic(random_code(), random_code());

		set_pace(0, 0);
		test_random_traffic(ERASE_RST, KILL_RST);

		wait_drained(DRAIN_WAIT);
		if (flushed_beats.size() != 0) begin
			$error("out_char: %0d beats never arrived", flushed_beats.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
